>>> rtl/tdp_pkg.sv
// shared types and constants for the trial division primality block
package tdp_pkg;

   typedef enum logic [1:0] {
      VERDICT_PRIME     = 2'd0,
      VERDICT_COMPOSITE = 2'd1,
      VERDICT_NEITHER   = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        load;         // capture incoming value, divisor to three
      logic        start_div;    // begin a division of value by divisor
      logic        div_step;     // one restoring division step
      logic        next_div;     // advance divisor to next odd number
      logic        set_verdict;  // latch verdict
      verdict_type verdict;
      logic        publish;      // move verdict into output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_neither;
      logic is_two;
      logic is_even;
      logic div_last;
      logic d_gt_q;
      logic rem_zero;
      logic out_free;
   } status_type;

endpackage

>>> rtl/tdp_ctrl.sv
// controller state machine for the trial division primality block
module tdp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tdp_pkg::status_type status,
   output tdp_pkg::cmd_type    cmd
);

   tdp_pkg::state_type state_ff;
   tdp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            if (req_valid) state_in = tdp_pkg::ST_CLASSIFY;
         end
         tdp_pkg::ST_CLASSIFY: begin
            if (status.is_neither || status.is_two || status.is_even) begin
               state_in = tdp_pkg::ST_DONE;
            end else begin
               state_in = tdp_pkg::ST_DIV;
            end
         end
         tdp_pkg::ST_DIV: begin
            if (status.div_last) state_in = tdp_pkg::ST_CHECK;
         end
         tdp_pkg::ST_CHECK: begin
            if (status.d_gt_q || status.rem_zero) begin
               state_in = tdp_pkg::ST_DONE;
            end else begin
               state_in = tdp_pkg::ST_DIV;
            end
         end
         tdp_pkg::ST_DONE: begin
            if (status.out_free) state_in = tdp_pkg::ST_IDLE;
         end
         default: state_in = tdp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.verdict = tdp_pkg::VERDICT_PRIME;
      req_stall = 1'b1;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         tdp_pkg::ST_CLASSIFY: begin
            priority if (status.is_neither) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = tdp_pkg::VERDICT_NEITHER;
            end else if (status.is_two) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = tdp_pkg::VERDICT_PRIME;
            end else if (status.is_even) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = tdp_pkg::VERDICT_COMPOSITE;
            end else begin
               cmd.start_div = 1'b1;
            end
         end
         tdp_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         tdp_pkg::ST_CHECK: begin
            priority if (status.d_gt_q) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = tdp_pkg::VERDICT_PRIME;
            end else if (status.rem_zero) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = tdp_pkg::VERDICT_COMPOSITE;
            end else begin
               cmd.next_div  = 1'b1;
               cmd.start_div = 1'b1;
            end
         end
         tdp_pkg::ST_DONE: begin
            cmd.publish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> rtl/tdp_dp.sv
// datapath: value, divisor, restoring divider and output register
module tdp_dp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [VALUE_WIDTH-1:0]   req_value,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_verdict,
   input  tdp_pkg::cmd_type         cmd,
   output tdp_pkg::status_type      status
);

   localparam int W     = VALUE_WIDTH;
   localparam int CNT_W = $clog2(W);

   logic [W-1:0]     n_ff, n_in;
   logic [W-1:0]     d_ff, d_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   tdp_pkg::verdict_type verdict_ff, verdict_in;
   tdp_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [W:0] rem_shift;
   logic [W:0] rem_sub;
   logic       fits;

   // restoring division step
   assign rem_shift = {rem_ff, quo_ff[W-1]};
   assign fits      = rem_shift >= {1'b0, d_ff};
   assign rem_sub   = rem_shift - {1'b0, d_ff};

   always_comb begin
      n_in           = n_ff;
      d_in           = d_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      verdict_in     = verdict_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         n_in = req_value;
         d_in = W'(3);
      end
      if (cmd.next_div) d_in = d_ff + W'(2);
      if (cmd.start_div) begin
         quo_in = n_ff;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[W-2:0], fits};
         rem_in = fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.set_verdict) verdict_in = cmd.verdict;
      if (cmd.publish) begin
         rsp_verdict_in = verdict_ff;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      d_ff           <= d_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign status.is_neither = n_ff[W-1] || (n_ff <= W'(1));
   assign status.is_two     = n_ff == W'(2);
   assign status.is_even    = !n_ff[0];
   assign status.div_last   = cnt_ff == CNT_W'(W - 1);
   assign status.d_gt_q     = d_ff > quo_ff;
   assign status.rem_zero   = rem_ff == '0;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

>>> rtl/trial_division_primality.sv
// top level of the trial division primality classifier
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_value   (VALUE_WIDTH, signed)
//   rsp      out        rsp_valid/rsp_stall   rsp_verdict (2 bits: prime, composite, neither)
//
// one transaction at a time; values that are negative, at most one, two or even
// finish after the classify state alone, plus output handoff
// an odd value is divided by each odd divisor in turn, from three, in the
// one-bit-per-cycle restoring divider, until one divides it or exceeds the quotient
// reset (synchronous, active high) clears the state machine and rsp_valid
// a new transaction is taken while a result still waits in the output register;
// rsp_stall only holds the machine in its final state when that register is full
module trial_division_primality #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_verdict
);

   // command and status between controller and datapath
   tdp_pkg::cmd_type    cmd;
   tdp_pkg::status_type status;

   // sequencing: classify, then divide / check per trial divisor
   tdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // value, divisor, quotient/remainder shift registers, output register
   tdp_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_value),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict),
      .cmd         (cmd),
      .status      (status)
   );

   // an accepted transaction keeps the input side busy until it completes
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("input accepted while previous transaction in flight");

   // a result never overwrites one that is still waiting
   a_publish_free: assert property (
      @(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free
   ) else $error("output register overwritten");

   // a published result shows up on the output
   a_publish_valid: assert property (
      @(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid
   ) else $error("published result not presented");

   // divider restart and divider step never collide
   a_div_cmd_excl: assert property (
      @(posedge clock) disable iff (reset)
      !(cmd.start_div && cmd.div_step)
   ) else $error("divider start and step together");

endmodule

>>> dv/tb.sv
// self-checking testbench for the trial division primality classifier
module tb;

   localparam int     WIDTH       = 32;
   localparam int     RANDOM_MIX  = 80;
   // the slowest clean run is dominated by one 31-bit prime
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam int     SETTLE      = 40;

   // one outstanding verdict, kept with the value that caused it for reporting
   typedef struct {
      logic [WIDTH-1:0]     value;
      tdp_pkg::verdict_type verdict;
   } owed_verdict_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [WIDTH-1:0] req_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [1:0]       rsp_verdict;

   owed_verdict_type verdicts_owed[$];
   int unsigned      errors      = 0;
   longint           cycle_count = 0;

   // knobs for the idle generators; tests switch them off for quiet stretches
   bit send_gaps_on = 1'b1;
   bit stalls_on    = 1'b1;

   trial_division_primality #(
      .VALUE_WIDTH(WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_verdict(rsp_verdict)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // classify a value the way the block should: negative, zero and one are
   // neither, two is prime, other evens composite, odd values by odd divisors
   // up to the square root; the divisor test avoids forming a square
   function automatic tdp_pkg::verdict_type predict_verdict(input logic [WIDTH-1:0] value);
      longint unsigned n;
      longint unsigned divisor;
      if (value[WIDTH-1])
         return tdp_pkg::VERDICT_NEITHER;
      n = value;
      if (n <= 1)
         return tdp_pkg::VERDICT_NEITHER;
      if (n == 2)
         return tdp_pkg::VERDICT_PRIME;
      if (n[0] == 1'b0)
         return tdp_pkg::VERDICT_COMPOSITE;
      for (divisor = 3; divisor <= n / divisor; divisor += 2) begin
         if (n % divisor == 0)
            return tdp_pkg::VERDICT_COMPOSITE;
      end
      return tdp_pkg::VERDICT_PRIME;
   endfunction

   // idle length between transactions: mostly none or short, now and then long
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 60);
   endfunction

   // random operand, biased so that the slow odd cases stay small
   function automatic logic [WIDTH-1:0] random_value();
      logic [WIDTH-1:0] value;
      longint unsigned  factor;
      longint unsigned  multiple;
      int unsigned      roll;
      roll  = $urandom_range(0, 99);
      value = $urandom();
      if (roll < 15) begin
         // negative, random low bits: always neither
         value[WIDTH-1] = 1'b1;
      end else if (roll < 30) begin
         // wide positive even: composite at once
         value[WIDTH-1] = 1'b0;
         value[0]       = 1'b0;
      end else if (roll < 35) begin
         value = $urandom_range(0, 2);
      end else if (roll < 75) begin
         // small odd: a real divisor search
         value = $urandom_range(3, 65535) | 1;
      end else if (roll < 80) begin
         value = $urandom_range(65537, 1048575) | 1;
      end else begin
         // wide multiple of a small prime: odd ones found early in the search, even ones at once
         case ($urandom_range(0, 4))
            0:       factor = 3;
            1:       factor = 5;
            2:       factor = 7;
            3:       factor = 11;
            default: factor = 13;
         endcase
         multiple = $urandom_range(1, 32'h7fff_ffff / factor);
         value    = WIDTH'(factor * multiple);
      end
      return value;
   endfunction

   // offer one transaction and hold it until taken, then maybe go idle
   task automatic send_value(input logic [WIDTH-1:0] value);
      int unsigned gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      gap = send_gaps_on ? idle_length() : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop offering and hold off until every owed verdict has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_owed.size() != 0)
         @(posedge clock);
   endtask

   // zero to five, nine and fifteen, including the squares four and nine
   task automatic test_small_values();
      logic [WIDTH-1:0] smalls[$] = '{0, 1, 2, 3, 4, 5, 9, 15};
      foreach (smalls[i])
         send_value(smalls[i]);
   endtask

   // most negative, minus one, largest even, largest odd composite and the
   // largest value, which is prime and walks the full divisor range
   task automatic test_extremes();
      send_value({1'b1, {(WIDTH-1){1'b0}}});
      send_value('1);
      send_value({1'b0, {(WIDTH-2){1'b1}}, 1'b0});
      send_value({1'b0, {(WIDTH-3){1'b1}}, 2'b01});
      send_value({1'b0, {(WIDTH-1){1'b1}}});
   endtask

   // squares of primes stop exactly at divisor squared equal to the value;
   // the two primes just below 65536 must run the search to the end
   task automatic test_prime_squares();
      logic [WIDTH-1:0] squares[$] = '{25, 49, 121, 169, 63001, 65521, 65519};
      foreach (squares[i])
         send_value(squares[i]);
   endtask

   // random mix with random idling on both sides, a quiet stretch in the
   // middle and a full drain now and then
   task automatic test_random_mix();
      for (int i = 0; i < RANDOM_MIX; i++) begin
         send_gaps_on = !(i >= 40 && i < 60);
         stalls_on    = !(i >= 40 && i < 60);
         if (i % 25 == 24)
            wait_drained();
         send_value(random_value());
      end
      send_gaps_on = 1'b1;
      stalls_on    = 1'b1;
   endtask

   // result side back-pressure: free stretches, short stalls, rare long ones
   int unsigned stall_left = 0;
   int unsigned free_left  = 0;
   always @(negedge clock) begin
      if (!stalls_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left != 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         free_left = $urandom_range(0, 30);
         case ($urandom_range(0, 99)) inside
            [0:69]:  stall_left = $urandom_range(0, 2);
            [70:96]: stall_left = $urandom_range(3, 10);
            default: stall_left = $urandom_range(50, 300);
         endcase
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   // both channels are sampled at the rising edge; accepted requests queue a
   // predicted verdict, accepted results are matched against the oldest one
   always @(posedge clock) begin
      owed_verdict_type oldest;
      if (!reset && req_valid && !req_stall)
         verdicts_owed.push_back('{value: req_value, verdict: predict_verdict(req_value)});
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected verdict, expected none, actual %0d",
                     $time, rsp_verdict);
         end else begin
            oldest = verdicts_owed.pop_front();
            if (rsp_verdict !== oldest.verdict) begin
               errors++;
               $display("%0t: verdict mismatch for value %0d, expected %0d (%s), actual %0d",
                        $time, $signed(oldest.value), oldest.verdict,
                        oldest.verdict.name(), rsp_verdict);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d verdicts outstanding",
                  $time, verdicts_owed.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_small_values();
      test_extremes();
      wait_drained();
      test_prime_squares();
      test_random_mix();

      // let everything come home, then give the block time to show extras
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
